### hdl/krt_pkg.sv
// shared types, codes and constants of the keyed record table
`timescale 1ns / 1ps

package krt_pkg;

  // default table depth
  localparam int KRT_ENTRIES = 64;

  // field widths
  localparam int REQ_W    = 3;
  localparam int KEY_W    = 16;
  localparam int YEAR_W   = 12;
  localparam int RATING_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // match count saturation value
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COUNT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_AVERAGE = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // request payload
  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    record_key;
    logic [YEAR_W-1:0]   record_year;
    logic [RATING_W-1:0] record_rating;
  } req_t;

  // response payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [YEAR_W-1:0]   out_year;
    logic [RATING_W-1:0] out_rating;
    logic [COUNT_W-1:0]  match_count;
    logic [RATING_W-1:0] average_rating;
  } rsp_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [YEAR_W-1:0]   year;
    logic [RATING_W-1:0] rating;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller to datapath commands
  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic scan_rd;
    logic commit;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;
    logic div_last;
    logic div_need;
    logic out_busy;
  } sts_t;

endpackage

### hdl/krt_stream_if.sv
// valid/ready stream interface carrying one payload type
`timescale 1ns / 1ps

interface krt_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### hdl/keyed_record_table.sv
// keyed record table top level: controller, datapath and channel hookup
//
//   channel   dir   payload                                         accepted when
//   in_req    in    req_type, record_key, record_year, record_rating  valid & ready
//   out_rsp   out   status, out_key, out_year, out_rating,            valid & ready
//                   match_count, average_rating
//
// every request scans all ENTRIES slots through the one read port of the slot
// memory before the response load; an average over a nonempty table adds a
// one-bit-per-cycle division of the rating sum by the record count
// after reset a clearing pass writes every slot empty, with in_req.ready low
// the response sits in an output register; a stalled out_rsp holds the
// response load, and the next request is taken the cycle after that load
`timescale 1ns / 1ps

module keyed_record_table import krt_pkg::*; #(
  parameter int ENTRIES = KRT_ENTRIES
) (
  input logic          clk,
  input logic          rst_n,
  krt_stream_if.sink   in_req,
  krt_stream_if.source out_rsp
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  rsp_t out_payload;
  req_t in_payload;

  assign in_payload = in_req.payload;

  // sequencing
  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // storage and arithmetic
  krt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_rsp.ready),
    .out_payload (out_payload)
  );

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid;
  assign out_rsp.payload = out_payload;

  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted while another is in flight");

  // the table is only written while no request can be taken
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clear_wr || cmd.commit) |-> !in_req.ready)
    else $error("slot memory written while ready to accept");

  // a response is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("response register overwritten");

  // match count cannot exceed the table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (int'(out_rsp.payload.match_count) <= ENTRIES))
    else $error("match count beyond table depth");

endmodule

### hdl/krt_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/krt_dpath.sv
// datapath: slot memory, scan accumulators, serial divider, response register
`timescale 1ns / 1ps

module krt_dpath import krt_pkg::*; #(
  parameter int ENTRIES = KRT_ENTRIES
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  input  req_t in_payload,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_payload
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int SW  = RATING_W + AW;
  localparam int DCW = $clog2(SW);
  localparam logic [AW-1:0]  ADDR_LAST = AW'(ENTRIES - 1);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(SW - 1);

  req_t             req_r;
  logic [AW-1:0]    addr_r;
  logic             rd_vld_r;
  logic [AW-1:0]    rd_idx_r;
  logic             found_r;
  logic [AW-1:0]    found_idx_r;
  rec_t             found_rec_r;
  logic             free_r;
  logic [AW-1:0]    free_idx_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [SW-1:0]    sum_r;
  logic [CW-1:0]    n_r;
  logic [SW-1:0]    quo_r;
  logic [CW-1:0]    rem_r;
  logic [DCW-1:0]   div_cnt_r;
  logic             out_valid_r;
  rsp_t             rsp_r;
  rsp_t             rsp_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  rec_t             ram_wdata;
  logic [REC_W-1:0] ram_rdata;
  rec_t             rd_rec;

  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;
  logic             trial_ge;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_rec = rec_t'(ram_rdata);

  // memory write select: clearing pass or request commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.commit) begin
      unique case (req_r.req_type)
        REQ_INSERT: begin
          if (!found_r && free_r) begin
            ram_we           = 1'b1;
            ram_waddr        = free_idx_r;
            ram_wdata.valid  = 1'b1;
            ram_wdata.key    = req_r.record_key;
            ram_wdata.year   = req_r.record_year;
            ram_wdata.rating = req_r.record_rating;
          end
        end
        REQ_REMOVE: begin
          if (found_r) begin
            ram_we          = 1'b1;
            ram_waddr       = found_idx_r;
            ram_wdata       = found_rec_r;
            ram_wdata.valid = 1'b0;
          end
        end
        REQ_UPDATE: begin
          if (found_r) begin
            ram_we           = 1'b1;
            ram_waddr        = found_idx_r;
            ram_wdata.valid  = 1'b1;
            ram_wdata.key    = found_rec_r.key;
            ram_wdata.year   = req_r.record_year;
            ram_wdata.rating = req_r.record_rating;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // address counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.capture) begin
        addr_r <= '0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
        addr_r <= addr_r + 1'b1;
      end
    end
  end

  // request capture and slot index of the read in flight
  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    if (cmd.capture) begin
      req_r <= in_payload;
    end
  end

  // scan flags and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      cnt_r   <= '0;
      sum_r   <= '0;
      n_r     <= '0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      cnt_r   <= '0;
      sum_r   <= '0;
      n_r     <= '0;
    end else if (rd_vld_r) begin
      if (rd_rec.valid && rd_rec.key == req_r.record_key && !found_r) begin
        found_r <= 1'b1;
      end
      if (!rd_rec.valid && !free_r) begin
        free_r <= 1'b1;
      end
      if (rd_rec.valid && rd_rec.year == req_r.record_year && cnt_r != COUNT_MAX) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (rd_rec.valid) begin
        sum_r <= sum_r + SW'(rd_rec.rating);
        n_r   <= n_r + 1'b1;
      end
    end
  end

  // first matching and first free slot captures
  always_ff @(posedge clk) begin
    if (rd_vld_r && rd_rec.valid && rd_rec.key == req_r.record_key && !found_r) begin
      found_idx_r <= rd_idx_r;
      found_rec_r <= rd_rec;
    end
    if (rd_vld_r && !rd_rec.valid && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign trial     = {rem_r, quo_r[SW-1]};
  assign trial_sub = trial - {1'b0, n_r};
  assign trial_ge  = trial >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r     <= sum_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[SW-2:0], trial_ge};
      rem_r     <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // response assembly
  always_comb begin
    rsp_nxt        = '0;
    rsp_nxt.status = ST_OK;
    unique case (req_r.req_type)
      REQ_INSERT: begin
        if (found_r) begin
          rsp_nxt.status = ST_DUP;
        end else if (!free_r) begin
          rsp_nxt.status = ST_FULL;
        end
      end
      REQ_REMOVE, REQ_LOOKUP: begin
        if (found_r) begin
          rsp_nxt.out_key    = found_rec_r.key;
          rsp_nxt.out_year   = found_rec_r.year;
          rsp_nxt.out_rating = found_rec_r.rating;
        end else begin
          rsp_nxt.status = ST_MISSING;
        end
      end
      REQ_UPDATE: begin
        if (found_r) begin
          rsp_nxt.out_key    = found_rec_r.key;
          rsp_nxt.out_year   = req_r.record_year;
          rsp_nxt.out_rating = req_r.record_rating;
        end else begin
          rsp_nxt.status = ST_MISSING;
        end
      end
      REQ_COUNT: begin
        rsp_nxt.match_count = cnt_r;
      end
      REQ_AVERAGE: begin
        if (n_r != '0) begin
          rsp_nxt.average_rating = quo_r[RATING_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = rsp_r;

  // status to controller
  assign sts.addr_last = (addr_r == ADDR_LAST);
  assign sts.div_last  = (div_cnt_r == DIV_LAST);
  assign sts.div_need  = (req_r.req_type == REQ_AVERAGE) && (n_r != '0);
  assign sts.out_busy  = out_valid_r && !out_ready;

endmodule

### hdl/krt_ctrl.sv
// controller: sequences clearing, scan, commit, divide and response load
`timescale 1ns / 1ps

module krt_ctrl import krt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_ACT,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_ACT;
      end
      S_ACT: begin
        cmd.commit = 1'b1;
        if (sts.div_need) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

### tb/sv/tb_keyed_record_table.sv
// self-checking testbench for the keyed record table with predictor and random traffic
`timescale 1ns / 1ps

module tb_keyed_record_table;
  import krt_pkg::*;

  localparam int ENTRIES   = KRT_ENTRIES;
  localparam int KEY_POOL  = 48;
  localparam int REQ_TOTAL = 540;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  krt_stream_if #(.payload_t(req_t)) in_req ();
  krt_stream_if #(.payload_t(rsp_t)) out_rsp ();

  keyed_record_table #(.ENTRIES(ENTRIES)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the record slots
  logic                shd_valid  [ENTRIES];
  logic [KEY_W-1:0]    shd_key    [ENTRIES];
  logic [YEAR_W-1:0]   shd_year   [ENTRIES];
  logic [RATING_W-1:0] shd_rating [ENTRIES];

  req_t req_backlog [$];
  rsp_t rsp_expected [$];

  // stimulus side view of which keys are stored
  logic [KEY_W-1:0]  live_keys [$];
  logic [KEY_W-1:0]  key_pool  [KEY_POOL];
  logic [YEAR_W-1:0] year_pool [4];

  int   mismatch_cnt = 0;
  int   rsp_seen = 0;
  bit   req_taken = 1'b0;
  int   send_gap = 0;
  int   send_calm = 0;
  int   hold_left = 0;
  int   rcv_calm = 0;
  bit   long_hold_done = 1'b0;
  rsp_t want_rsp;
  rsp_t got_rsp;

  // apply one request to the shadow slots and return its response
  function automatic rsp_t serve_request(req_t rq);
    rsp_t        r;
    int          hit;
    int          free_slot;
    int          n;
    logic [31:0] sum;
    r = '0;
    hit = -1;
    free_slot = -1;
    n = 0;
    sum = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shd_valid[i] && shd_key[i] == rq.record_key && hit < 0) hit = i;
      if (!shd_valid[i] && free_slot < 0) free_slot = i;
    end
    case (rq.req_type)
      REQ_INSERT: begin
        // duplicate check wins over the full check
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          shd_valid[free_slot]  = 1'b1;
          shd_key[free_slot]    = rq.record_key;
          shd_year[free_slot]   = rq.record_year;
          shd_rating[free_slot] = rq.record_rating;
          r.status = ST_OK;
        end
      end
      REQ_REMOVE, REQ_UPDATE, REQ_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          if (rq.req_type == REQ_UPDATE) begin
            shd_year[hit]   = rq.record_year;
            shd_rating[hit] = rq.record_rating;
          end
          r.status     = ST_OK;
          r.out_key    = shd_key[hit];
          r.out_year   = shd_year[hit];
          r.out_rating = shd_rating[hit];
          if (rq.req_type == REQ_REMOVE) shd_valid[hit] = 1'b0;
        end
      end
      REQ_COUNT: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shd_valid[i] && shd_year[i] == rq.record_year) n++;
        r.status = ST_OK;
        r.match_count = (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
      end
      REQ_AVERAGE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shd_valid[i]) begin
            sum = sum + shd_rating[i];
            n++;
          end
        end
        r.status = ST_OK;
        r.average_rating = (n == 0) ? '0 : RATING_W'(sum / n);
      end
      default: ;
    endcase
    return r;
  endfunction

  // stimulus helpers
  function automatic int live_index(logic [KEY_W-1:0] k);
    foreach (live_keys[i])
      if (live_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int hit_pct);
    if (live_keys.size() > 0 && $urandom_range(0, 99) < hit_pct)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if ($urandom_range(0, 1) == 1) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return KEY_W'($urandom);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    while (live_index(k) >= 0) k = KEY_W'($urandom);
    return k;
  endfunction

  function automatic logic [YEAR_W-1:0] pick_year();
    if ($urandom_range(0, 9) < 7) return year_pool[$urandom_range(0, 3)];
    return YEAR_W'($urandom);
  endfunction

  function automatic logic [RATING_W-1:0] pick_rating();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return RATING_W'($urandom);
  endfunction

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 160);
  endfunction

  task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] rkey,
                           input logic [YEAR_W-1:0] ryear, input logic [RATING_W-1:0] rrating);
    req_t rq;
    int   idx;
    rq.req_type      = kind;
    rq.record_key    = rkey;
    rq.record_year   = ryear;
    rq.record_rating = rrating;
    req_backlog.push_back(rq);
    idx = live_index(rkey);
    if (kind == REQ_INSERT && idx < 0 && live_keys.size() < ENTRIES)
      live_keys.push_back(rkey);
    else if (kind == REQ_REMOVE && idx >= 0)
      live_keys.delete(idx);
  endtask

  // fill the table past full, probe it, then drain it key by key
  task automatic run_fill_drain();
    logic [YEAR_W-1:0] fill_year;
    logic [KEY_W-1:0]  k;
    fill_year = pick_year();
    while (live_keys.size() < ENTRIES)
      queue_req(REQ_INSERT, fresh_key(),
                ($urandom_range(0, 4) != 0) ? fill_year : pick_year(), pick_rating());
    repeat (3) queue_req(REQ_INSERT, fresh_key(), pick_year(), pick_rating());
    queue_req(REQ_INSERT, pick_key(100), pick_year(), pick_rating());
    queue_req(REQ_COUNT, KEY_W'($urandom), fill_year, RATING_W'($urandom));
    queue_req(REQ_AVERAGE, KEY_W'($urandom), YEAR_W'($urandom), RATING_W'($urandom));
    repeat (4) queue_req(REQ_UPDATE, pick_key(100), pick_year(), pick_rating());
    queue_req(REQ_COUNT, KEY_W'($urandom), fill_year, RATING_W'($urandom));
    while (live_keys.size() > 0) begin
      k = pick_key(100);
      queue_req(REQ_REMOVE, k, YEAR_W'($urandom), RATING_W'($urandom));
      if ($urandom_range(0, 3) == 0)
        queue_req(REQ_LOOKUP, k, YEAR_W'($urandom), RATING_W'($urandom));
      if ($urandom_range(0, 7) == 0)
        queue_req(REQ_AVERAGE, KEY_W'($urandom), YEAR_W'($urandom), RATING_W'($urandom));
    end
    queue_req(REQ_AVERAGE, KEY_W'($urandom), YEAR_W'($urandom), RATING_W'($urandom));
  endtask

  // mixed traffic biased toward growing or shrinking the table
  task automatic run_mixed(input bit grow);
    int r;
    int ins_cut;
    int rem_cut;
    ins_cut = grow ? 45 : 15;
    rem_cut = ins_cut + (grow ? 10 : 35);
    repeat (60) begin
      r = $urandom_range(0, 99);
      if (r < ins_cut)
        queue_req(REQ_INSERT, pick_key(20), pick_year(), pick_rating());
      else if (r < rem_cut)
        queue_req(REQ_REMOVE, pick_key(80), YEAR_W'($urandom), RATING_W'($urandom));
      else if (r < rem_cut + 12)
        queue_req(REQ_UPDATE, pick_key(80), pick_year(), pick_rating());
      else if (r < rem_cut + 28)
        queue_req(REQ_LOOKUP, pick_key(80), YEAR_W'($urandom), RATING_W'($urandom));
      else if (r < rem_cut + 36)
        queue_req(REQ_COUNT, KEY_W'($urandom), pick_year(), RATING_W'($urandom));
      else if (r < rem_cut + 42)
        queue_req(REQ_AVERAGE, KEY_W'($urandom), YEAR_W'($urandom), RATING_W'($urandom));
      else if (r < rem_cut + 44)
        queue_req(($urandom_range(0, 1) == 1) ? REQ_SPARE7 : REQ_SPARE6,
                  KEY_W'($urandom), YEAR_W'($urandom), RATING_W'($urandom));
      else
        queue_req(REQ_INSERT, fresh_key(), YEAR_W'($urandom), RATING_W'($urandom));
    end
  endtask

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (!in_req.valid || req_taken) begin
        if (req_taken) begin
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = draw_gap();
            if ($urandom_range(0, 29) == 0) send_calm = 40;
          end
        end
        if (send_gap > 0) begin
          send_gap--;
          in_req.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          in_req.valid   <= 1'b1;
          in_req.payload <= req_backlog.pop_front();
        end else begin
          in_req.valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
    end
  end

  // response receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (!long_hold_done && rsp_seen >= 120) begin
        hold_left = 500;
        long_hold_done = 1'b1;
      end
      if (rcv_calm > 0) begin
        rcv_calm--;
      end else if (hold_left == 0 && $urandom_range(0, 5) == 0) begin
        hold_left = draw_gap();
        if ($urandom_range(0, 29) == 0) rcv_calm = 40;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each accepted request, check each accepted response
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        rsp_expected.push_back(serve_request(in_req.payload));
        req_taken = 1'b1;
      end
      if (out_rsp.valid && out_rsp.ready) begin
        rsp_seen++;
        got_rsp = out_rsp.payload;
        if (rsp_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: response with no request pending, status %0d",
                     $time, got_rsp.status);
        end else begin
          want_rsp = rsp_expected.pop_front();
          if (got_rsp.status !== want_rsp.status || got_rsp.out_key !== want_rsp.out_key ||
              got_rsp.out_year !== want_rsp.out_year ||
              got_rsp.out_rating !== want_rsp.out_rating ||
              got_rsp.match_count !== want_rsp.match_count ||
              got_rsp.average_rating !== want_rsp.average_rating) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t: response %0d exp st=%0d key=%h yr=%h rt=%h cnt=%0d avg=%h",
                       $time, rsp_seen, want_rsp.status, want_rsp.out_key,
                       want_rsp.out_year, want_rsp.out_rating, want_rsp.match_count,
                       want_rsp.average_rating, "\n    got st=%0d key=%h yr=%h rt=%h ",
                       got_rsp.status, got_rsp.out_key, got_rsp.out_year,
                       got_rsp.out_rating, "cnt=%0d avg=%h", got_rsp.match_count,
                       got_rsp.average_rating);
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int epoch;
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.payload = '0;
    out_rsp.ready = 1'b0;
    foreach (shd_valid[i]) begin
      shd_valid[i]  = 1'b0;
      shd_key[i]    = '0;
      shd_year[i]   = '0;
      shd_rating[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    year_pool[0] = '0;
    year_pool[1] = '1;
    year_pool[2] = YEAR_W'($urandom);
    year_pool[3] = YEAR_W'($urandom);

    // directed: empty table, field extremes, duplicates, missing keys, spare codes
    queue_req(REQ_AVERAGE, 16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_COUNT,   16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_LOOKUP,  16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_REMOVE,  16'hffff, 12'hfff, 16'hffff);
    queue_req(REQ_UPDATE,  16'h1234, 12'h7b2, 16'h0180);
    queue_req(REQ_INSERT,  16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_INSERT,  16'hffff, 12'hfff, 16'hffff);
    queue_req(REQ_INSERT,  16'h0000, 12'h123, 16'h4567);
    queue_req(REQ_LOOKUP,  16'hffff, 12'h000, 16'h0000);
    queue_req(REQ_LOOKUP,  16'h0000, 12'hfff, 16'hffff);
    queue_req(REQ_UPDATE,  16'h0000, 12'hfff, 16'hffff);
    queue_req(REQ_COUNT,   16'h0000, 12'hfff, 16'h0000);
    queue_req(REQ_COUNT,   16'hffff, 12'h000, 16'hffff);
    queue_req(REQ_AVERAGE, 16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_SPARE6,  16'hffff, 12'hfff, 16'hffff);
    queue_req(REQ_SPARE7,  16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_REMOVE,  16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_LOOKUP,  16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_UPDATE,  16'h0000, 12'h555, 16'h5555);
    queue_req(REQ_AVERAGE, 16'hffff, 12'hfff, 16'hffff);
    queue_req(REQ_INSERT,  16'h5555, 12'haaa, 16'haaaa);
    queue_req(REQ_INSERT,  16'haaaa, 12'h555, 16'h5555);
    queue_req(REQ_AVERAGE, 16'h0000, 12'h000, 16'h0000);
    queue_req(REQ_REMOVE,  16'hffff, 12'h000, 16'h0000);
    queue_req(REQ_COUNT,   16'h0000, 12'h555, 16'h0000);

    // random: full/drain cycles between mixed epochs
    epoch = 0;
    while (req_backlog.size() < REQ_TOTAL) begin
      if (epoch % 4 == 0)
        run_fill_drain();
      else
        run_mixed(epoch % 2 == 1);
      epoch++;
    end

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() > 0 || in_req.valid || rsp_expected.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_cnt == 0 && rsp_expected.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
